// ----- hw/rtl/encoder_rpm_iir_estimator_top_defines.svh -----
// ---------------------------------------------------------------------------
// encoder rpm estimator assertion macros
// shared concurrent check forms, clocked on clk and gated by rst_n
// ---------------------------------------------------------------------------
`ifndef ENCODER_RPM_IIR_ESTIMATOR_TOP_DEFINES_SVH
`define ENCODER_RPM_IIR_ESTIMATOR_TOP_DEFINES_SVH

// same-cycle implication check
`define ERPM_CHK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication check
`define ERPM_CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/erpm_pkg.sv -----
// ---------------------------------------------------------------------------
// erpm_pkg
// shared types and constants of the encoder rpm estimator
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package erpm_pkg;

  // field widths
  localparam int PPR_W      = 10;
  localparam int SPEED_W    = 32;
  localparam int COUNT_W    = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int BLEND_W    = 35;

  // parameter defaults
  localparam int TIME_BITS_DEF  = 48;
  localparam int SPEED_FRAC_DEF = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PPR   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STALL = 1'd1;

  // register reset values
  localparam logic [PPR_W-1:0]      PPR_RESET   = 10'd20;
  localparam logic [CFG_DATA_W-1:0] STALL_RESET = 32'd2000000;

  // command codes
  localparam logic CMD_START  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // arithmetic constants
  localparam logic [63:0]        USEC_PER_MIN = 64'd60000000;
  localparam logic [SPEED_W-1:0] SPEED_MAX    = 32'hFFFF_FFFF;
  localparam int                 BLEND_DIV    = 5;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL,
    ST_QSTART,
    ST_QWAIT,
    ST_BLEND,
    ST_BMUL,
    ST_OUT
  } erpm_state_t;

  // divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- hw/rtl/erpm_in_if.sv -----
// ---------------------------------------------------------------------------
// erpm_in_if
// input channel: command, pulse count and timestamp words
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface erpm_in_if #(
  parameter int TIME_BITS = erpm_pkg::TIME_BITS_DEF
);
  import erpm_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      command;
  logic signed [COUNT_W-1:0] pulse_count;
  logic [TIME_BITS-1:0]      time_us;

  modport source (output valid, command, pulse_count, time_us, input ready);
  modport sink   (input valid, command, pulse_count, time_us, output ready);
endinterface

// ----- hw/rtl/erpm_out_if.sv -----
// ---------------------------------------------------------------------------
// erpm_out_if
// result channel: filtered speed and per-sample flags
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface erpm_out_if;
  import erpm_pkg::*;

  logic               valid;
  logic               ready;
  logic [SPEED_W-1:0] speed_q8;
  logic               pulses_seen;
  logic               stalled;

  modport source (output valid, speed_q8, pulses_seen, stalled, input ready);
  modport sink   (input valid, speed_q8, pulses_seen, stalled, output ready);
endinterface

// ----- hw/rtl/erpm_div.sv -----
// ---------------------------------------------------------------------------
// erpm_div
// shared restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module erpm_div #(
  parameter int DIVIDEND_W = erpm_pkg::BLEND_W,
  parameter int DIVISOR_W  = erpm_pkg::BLEND_W
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [DIVIDEND_W-1:0]  dividend,
  input  logic [DIVISOR_W-1:0]   divisor,
  output logic [DIVIDEND_W-1:0]  quotient,
  output erpm_pkg::div_stat_t    stat
);
  import erpm_pkg::*;

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [CNT_W-1:0]      cnt_r;
  logic                  done_r;
  logic [DIVISOR_W-1:0]  rem_r;
  logic [DIVISOR_W-1:0]  rem_nxt;
  logic [DIVIDEND_W-1:0] dvd_r;
  logic [DIVISOR_W-1:0]  dsr_r;
  logic [DIVISOR_W:0]    rem_sh;
  logic [DIVISOR_W:0]    rem_diff;
  logic                  fits;

  // trial subtract of the shifted remainder
  always_comb begin
    rem_sh   = {rem_r, dvd_r[DIVIDEND_W-1]};
    rem_diff = rem_sh - {1'b0, dsr_r};
    fits     = (rem_sh >= {1'b0, dsr_r});
    rem_nxt  = fits ? rem_diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
  end

  // iteration counter and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CNT_W'(DIVIDEND_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvd_r <= dividend;
      dsr_r <= divisor;
    end else if (cnt_r != '0) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[DIVIDEND_W-2:0], fits};
    end
  end

  assign quotient  = dvd_r;
  assign stat.busy = (cnt_r != '0);
  assign stat.done = done_r;

endmodule

// ----- hw/rtl/encoder_rpm_iir_estimator_top.sv -----
// Sequence: each word is captured in idle and evaluated; a start or a sample with no new
//   speed then goes to output, a forced speed (zero pulses per rev or too long a gap) goes
//   via blend, a divided one via multiply and divider first; a held result stalls output.
// Throughput: one word at a time, the next taken as soon as its result is offered.
// Reset: synchronous, active low; speed, kept count and pulse time clear to zero,
//   registers return to 20 pulses per rev and a 2 s stall timeout.
// ---------------------------------------------------------------------------
// encoder_rpm_iir_estimator_top
// encoder tachometer with a first-order iir speed filter
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "encoder_rpm_iir_estimator_top_defines.svh"

module encoder_rpm_iir_estimator_top #(
  parameter int TIME_BITS       = erpm_pkg::TIME_BITS_DEF,
  parameter int SPEED_FRAC_BITS = erpm_pkg::SPEED_FRAC_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  erpm_in_if.sink                         in_ch,
  erpm_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [erpm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [erpm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import erpm_pkg::*;

  // numerator 60e6 scaled to the fixed-point speed, and derived widths
  localparam logic [63:0] NUM      = USEC_PER_MIN << SPEED_FRAC_BITS;
  localparam int          NUM_BITS = $clog2(NUM + 64'd1);
  localparam int          PW       = NUM_BITS + PPR_W;
  localparam int          DDW      = (NUM_BITS > BLEND_W) ? NUM_BITS : BLEND_W;

  // reciprocal of five: exact floor division of any 32-bit value
  localparam logic [SPEED_W-1:0] RECIP5       = 32'hCCCC_CCCD;
  localparam int                 RECIP5_SHIFT = 34;

  erpm_state_t state_r, state_nxt;

  // configuration
  logic [PPR_W-1:0]      ppr_r;
  logic [CFG_DATA_W-1:0] stall_r;

  // kept state
  logic signed [COUNT_W-1:0] prev_count_r;
  logic [TIME_BITS-1:0]      prev_time_r;
  logic [SPEED_W-1:0]        filt_r;

  // captured word and working values
  logic                      cmd_r;
  logic signed [COUNT_W-1:0] count_r;
  logic [TIME_BITS-1:0]      time_r;
  logic [NUM_BITS-1:0]       dt_r;
  logic [PW-1:0]             prod_r;
  logic [SPEED_W-1:0]        nv_r;
  logic                      seen_r;
  logic                      stall_flag_r;
  logic [SPEED_W-1:0]        diff_r;
  logic                      up_r;

  // result register
  logic               out_valid_r;
  logic [SPEED_W-1:0] out_speed_r;
  logic               out_seen_r;
  logic               out_stall_r;

  // sequencer controls
  logic in_ready;
  logic eval_en;
  logic mul_en;
  logic div_start;
  logic blend_en;
  logic q_take;
  logic f_take;
  logic out_load;

  // evaluation of the captured word
  logic [TIME_BITS-1:0] dt;
  logic                 rise;
  logic                 dt_zero;
  logic                 dt_big;
  logic                 over_timeout;

  // divider hookup
  logic [DDW-1:0]     div_dividend;
  logic [PW-1:0]      div_divisor;
  logic [DDW-1:0]     div_quot;
  div_stat_t          div_st;
  logic [SPEED_W-1:0] q_sat;

  // blend by five
  logic [2*SPEED_W-1:0] fifth_prod;
  logic [SPEED_W-1:0]   fifth;
  logic [SPEED_W-1:0]   blend_nxt;

  // gap and comparisons
  always_comb begin
    dt           = time_r - prev_time_r;
    rise         = (count_r > prev_count_r);
    dt_zero      = (dt == '0);
    dt_big       = (64'(dt) > NUM);
    over_timeout = (64'(dt) > 64'(stall_r));
    q_sat        = (div_quot[DDW-1:SPEED_W] != '0) ? SPEED_MAX : div_quot[SPEED_W-1:0];
  end

  // (4*old + new) / 5 as old plus or minus a fifth of their gap
  always_comb begin
    fifth_prod = (2*SPEED_W)'(diff_r) * (2*SPEED_W)'(RECIP5);
    fifth      = SPEED_W'(fifth_prod >> RECIP5_SHIFT);
    blend_nxt  = up_r ? filt_r + fifth : filt_r + ~fifth;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (cmd_r == CMD_SAMPLE && rise && !dt_zero) begin
          if (ppr_r == '0 || dt_big) state_nxt = ST_BLEND;
          else                       state_nxt = ST_MUL;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_MUL:    state_nxt = ST_QSTART;
      ST_QSTART: state_nxt = ST_QWAIT;
      ST_QWAIT: begin
        if (div_st.done) state_nxt = ST_BLEND;
      end
      ST_BLEND:  state_nxt = ST_BMUL;
      ST_BMUL:   state_nxt = ST_OUT;
      ST_OUT: begin
        if (!out_valid_r || out_ch.ready) state_nxt = ST_IDLE;
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    eval_en   = 1'b0;
    mul_en    = 1'b0;
    div_start = 1'b0;
    blend_en  = 1'b0;
    q_take    = 1'b0;
    f_take    = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE:   in_ready  = 1'b1;
      ST_EVAL:   eval_en   = 1'b1;
      ST_MUL:    mul_en    = 1'b1;
      ST_QSTART: div_start = 1'b1;
      ST_QWAIT:  q_take    = div_st.done;
      ST_BLEND:  blend_en  = 1'b1;
      ST_BMUL:   f_take    = 1'b1;
      ST_OUT:    out_load  = !out_valid_r || out_ch.ready;
      default:   in_ready  = 1'b0;
    endcase
  end

  // divider operands: scaled numerator over gap times pulses per rev
  assign div_dividend = DDW'(NUM);
  assign div_divisor  = prod_r;

  erpm_div #(
    .DIVIDEND_W (DDW),
    .DIVISOR_W  (PW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quot),
    .stat     (div_st)
  );

  // state, configuration, kept state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      ppr_r        <= PPR_RESET;
      stall_r      <= STALL_RESET;
      prev_count_r <= '0;
      prev_time_r  <= '0;
      filt_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_PPR:   ppr_r   <= cfg_data[PPR_W-1:0];
          CFG_STALL: stall_r <= cfg_data;
          default:   ppr_r   <= ppr_r;
        endcase
      end
      if (eval_en) begin
        if (cmd_r == CMD_START) begin
          prev_count_r <= '0;
          prev_time_r  <= time_r;
        end else if (rise) begin
          prev_count_r <= count_r;
          prev_time_r  <= time_r;
        end else if (over_timeout) begin
          filt_r <= '0;
        end
      end
      if (f_take) filt_r <= blend_nxt;
      if (out_load)                    out_valid_r <= 1'b1;
      else if (out_ch.ready)           out_valid_r <= 1'b0;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      cmd_r   <= in_ch.command;
      count_r <= in_ch.pulse_count;
      time_r  <= in_ch.time_us;
    end
    if (eval_en) begin
      seen_r       <= (cmd_r == CMD_SAMPLE) && rise;
      stall_flag_r <= (cmd_r == CMD_SAMPLE) && !rise && over_timeout;
      dt_r         <= NUM_BITS'(64'(dt));
      if (ppr_r == '0) nv_r <= SPEED_MAX;
      else             nv_r <= '0;
    end
    if (mul_en) prod_r <= PW'(dt_r) * PW'(ppr_r);
    if (q_take) nv_r   <= q_sat;
    // gap between new and kept speed, less one when falling
    if (blend_en) begin
      up_r   <= (nv_r >= filt_r);
      diff_r <= (nv_r >= filt_r) ? nv_r - filt_r : filt_r + ~nv_r;
    end
    if (out_load) begin
      out_speed_r <= filt_r;
      out_seen_r  <= seen_r;
      out_stall_r <= stall_flag_r;
    end
  end

  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.speed_q8    = out_speed_r;
  assign out_ch.pulses_seen = out_seen_r;
  assign out_ch.stalled     = out_stall_r;

  // checks
  `ERPM_CHK(a_ready_div_idle, in_ready, !div_st.busy, "word taken while divider busy")
  `ERPM_CHK(a_flags_excl, out_valid_r, !(out_seen_r && out_stall_r), "seen and stalled together")
  `ERPM_CHK(a_stall_zero, out_valid_r && out_stall_r, out_speed_r == '0, "stall with speed")
  `ERPM_CHK_NEXT(a_div_runs, div_start, div_st.busy, "divider did not start")

endmodule

// ----- test/tb.sv -----
// ---------------------------------------------------------------------------
// tb
// checks the encoder rpm estimator against a cycle-free predictor of the
// speed filter; directed words first, then randomised start/sample runs
// under several register settings and handshake idling patterns
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import erpm_pkg::*;

  localparam int TW = TIME_BITS_DEF;

  // predictor of the tachometer plus the queue of expected result words
  class rpm_scoreboard;
    typedef struct {
      logic [SPEED_W-1:0] speed_q8;
      logic               pulses_seen;
      logic               stalled;
    } rpm_result_t;

    logic [PPR_W-1:0]          ppr;
    logic [CFG_DATA_W-1:0]     stall_us;
    logic signed [COUNT_W-1:0] kept_count;
    logic [TW-1:0]             pulse_stamp;
    logic [SPEED_W-1:0]        speed;
    rpm_result_t               expected_q[$];
    int unsigned               errors;

    function new();
      ppr         = PPR_RESET;
      stall_us    = STALL_RESET;
      kept_count  = '0;
      pulse_stamp = '0;
      speed       = '0;
      errors      = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_PPR:   ppr = data[PPR_W-1:0];
        CFG_STALL: stall_us = data;
        default: ;
      endcase
    endfunction

    // instantaneous speed in q24.8, saturating
    function logic [SPEED_W-1:0] instant_rpm(logic [TW-1:0] dt);
      logic [63:0] num;
      logic [63:0] q;
      num = USEC_PER_MIN << SPEED_FRAC_DEF;
      if (ppr == 0) return SPEED_MAX;
      if (64'(dt) > num) return '0;
      q = num / (64'(dt) * 64'(ppr));
      if (q > 64'(SPEED_MAX)) return SPEED_MAX;
      return q[SPEED_W-1:0];
    endfunction

    function void note_word(logic cmd, logic signed [COUNT_W-1:0] count, logic [TW-1:0] stamp);
      logic [TW-1:0]      dt;
      logic [SPEED_W-1:0] fresh;
      logic [63:0]        mix;
      rpm_result_t        res;
      dt              = stamp - pulse_stamp;
      res.pulses_seen = 1'b0;
      res.stalled     = 1'b0;
      if (cmd == CMD_START) begin
        kept_count  = '0;
        pulse_stamp = stamp;
      end else if (count > kept_count) begin
        res.pulses_seen = 1'b1;
        pulse_stamp     = stamp;
        kept_count      = count;
        // a zero gap keeps the filtered speed
        if (dt != 0) begin
          fresh = instant_rpm(dt);
          mix   = (4 * 64'(speed) + 64'(fresh)) / BLEND_DIV;
          speed = mix[SPEED_W-1:0];
        end
      end else if (dt > TW'(stall_us)) begin
        speed       = '0;
        res.stalled = 1'b1;
      end
      res.speed_q8 = speed;
      expected_q.push_back(res);
    endfunction

    task report(string what);
      errors++;
      // keep the log short on a badly broken build
      if (errors <= 50) $display("%0t mismatch: %s", $realtime, what);
    endtask

    task check_result(logic [SPEED_W-1:0] speed_q8, logic seen, logic stalled);
      rpm_result_t want;
      if (expected_q.size() == 0) begin
        report("result word with no input word outstanding");
        return;
      end
      want = expected_q.pop_front();
      if (speed_q8 !== want.speed_q8)
        report($sformatf("speed_q8 got %0h want %0h", speed_q8, want.speed_q8));
      if (seen !== want.pulses_seen)
        report($sformatf("pulses_seen got %b want %b", seen, want.pulses_seen));
      if (stalled !== want.stalled)
        report($sformatf("stalled got %b want %b", stalled, want.stalled));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int unsigned           tx_idle_pct;
  int unsigned           rx_stall_pct;
  logic [CFG_DATA_W-1:0] cur_stall;
  rpm_scoreboard         sb = new();

  erpm_in_if #(.TIME_BITS(TW)) in_ch();
  erpm_out_if                  out_ch();

  encoder_rpm_iir_estimator_top #(
    .TIME_BITS      (TW),
    .SPEED_FRAC_BITS(SPEED_FRAC_DEF)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #4 clk = ~clk;

  // result side: check accepted words, then pick next ready
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.speed_q8, out_ch.pulses_seen, out_ch.stalled);
    out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // run limit
  initial begin
    #40_000_000;
    $display("encoder_rpm_iir_estimator_top regression: fail");
    $finish;
  end

  function automatic logic [TW-1:0] rand48();
    return {16'($urandom_range(0, 16'hFFFF)), 32'($urandom)};
  endfunction

  // gap between pulse times, spread over several decades
  function automatic logic [TW-1:0] rand_gap();
    case ($urandom_range(3))
      0:       return TW'($urandom_range(1, 50));
      1:       return TW'($urandom_range(50, 5000));
      2:       return TW'($urandom_range(5000, 500000));
      default: return TW'($urandom_range(500000, 3000000));
    endcase
  endfunction

  // present one word, idling first at the current sender rate; entered on a clock edge
  task send_word(logic cmd, logic signed [COUNT_W-1:0] count, logic [TW-1:0] stamp);
    int unsigned gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.command     <= cmd;
    in_ch.pulse_count <= count;
    in_ch.time_us     <= stamp;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_word(cmd, count, stamp);
  endtask

  // drop valid and wait for every outstanding result word
  task hold_off();
    in_ch.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  task write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    hold_off();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_register(idx, data);
    if (idx == CFG_STALL) cur_stall = data;
  endtask

  // mostly start-then-samples runs with random content, the rest noise words
  task run_traffic(int unsigned n_words, int unsigned tx_pct, int unsigned rx_pct);
    int unsigned               sent;
    int unsigned               len;
    int unsigned               pick;
    bit                        drained;
    logic signed [COUNT_W-1:0] cnt;
    logic [TW-1:0]             now;
    logic [TW-1:0]             pulse_t;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    sent         = 0;
    drained      = 1'b0;
    while (sent < n_words) begin
      // one full drain half way through
      if (!drained && sent >= n_words / 2) begin
        hold_off();
        drained = 1'b1;
      end
      if ($urandom_range(99) < 15) begin
        send_word(1'($urandom_range(1)), $urandom, rand48());
        sent++;
      end else begin
        case ($urandom_range(9))
          0, 1:    now = rand48();
          2, 3:    now = '1 - TW'($urandom_range(0, 100000));
          default: now = TW'($urandom);
        endcase
        pulse_t = now;
        cnt     = ($urandom_range(9) == 0) ? 32'sh7FFF_FF00 : '0;
        send_word(CMD_START, $urandom, now);
        sent++;
        len = $urandom_range(1, 12);
        repeat (len) begin
          pick = $urandom_range(99);
          if (pick < 65) begin
            cnt     = cnt + $urandom_range(1, 8);
            now     = pulse_t + rand_gap();
            pulse_t = now;
          end else if (pick < 72) begin
            // rise with no elapsed time
            cnt = cnt + 1;
            now = pulse_t;
          end else begin
            // no rise, either just around the stall limit or inside it
            cnt = cnt - $urandom_range(0, 3);
            if ($urandom_range(1))
              now = pulse_t + TW'(cur_stall) + TW'($urandom_range(0, 1));
            else
              now = pulse_t + TW'($urandom_range(0, cur_stall));
          end
          send_word(CMD_SAMPLE, cnt, now);
          sent++;
        end
      end
    end
  endtask

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.command     = CMD_START;
    in_ch.pulse_count = '0;
    in_ch.time_us     = '0;
    out_ch.ready      = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = CFG_PPR;
    cfg_data          = '0;
    tx_idle_pct       = 0;
    rx_stall_pct      = 0;
    cur_stall         = STALL_RESET;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words at the reset register values
    send_word(CMD_SAMPLE, 0, 0);                      // no rise, zero gap
    send_word(CMD_START, 32'sh1234_5678, 1000);
    send_word(CMD_SAMPLE, 1, 1000);                   // rise with zero gap
    send_word(CMD_SAMPLE, 5, 2000);                   // first real speed
    send_word(CMD_SAMPLE, 5, 2_002_000);              // gap equal to the timeout
    send_word(CMD_SAMPLE, 4, 2_002_001);              // gap just over the timeout
    send_word(CMD_SAMPLE, 32'sh7FFF_FFFF, 2_002_002); // largest count
    send_word(CMD_SAMPLE, 32'sh8000_0000, 5);         // smallest count, time went back
    send_word(CMD_START, 0, '1);                      // start at the top of the timer
    send_word(CMD_SAMPLE, 3, 4);                      // timer wraps
    send_word(CMD_SAMPLE, 4, 48'h0400_0000_0004);     // gap too long for any speed

    // one pulse per rev and no stall margin: saturation and instant stall
    write_register(CFG_PPR, 1);
    write_register(CFG_STALL, 0);
    send_word(CMD_START, 0, 100);
    send_word(CMD_SAMPLE, 1, 101);
    send_word(CMD_SAMPLE, 1, 101);
    send_word(CMD_SAMPLE, 1, 102);

    // zero pulses per rev and the longest timeout
    write_register(CFG_PPR, 0);
    write_register(CFG_STALL, 32'hFFFF_FFFF);
    send_word(CMD_START, 0, 7);
    send_word(CMD_SAMPLE, 10, 1000);
    send_word(CMD_SAMPLE, 11, '1);
    send_word(CMD_SAMPLE, 11, 48'h8000_0000_0000);
    send_word(CMD_SAMPLE, 32'sh8000_0001, 48'h8000_0000_0001);

    // random traffic over several settings and idling patterns
    write_register(CFG_PPR, PPR_RESET);
    write_register(CFG_STALL, STALL_RESET);
    run_traffic(320, 0, 0);
    write_register(CFG_PPR, 1);
    write_register(CFG_STALL, 0);
    run_traffic(320, 54, 0);
    write_register(CFG_PPR, 1023);
    write_register(CFG_STALL, 32'hFFFF_FFFF);
    run_traffic(320, 0, 54);
    write_register(CFG_PPR, $urandom_range(1, 1023));
    write_register(CFG_STALL, $urandom_range(1000, 5000000));
    run_traffic(320, 10, 10);
    write_register(CFG_PPR, 360);
    write_register(CFG_STALL, 50000);
    run_traffic(320, 0, 0);

    hold_off();
    repeat (90) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("encoder_rpm_iir_estimator_top regression: pass");
    else
      $display("encoder_rpm_iir_estimator_top regression: fail");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/erpm_pkg.sv
hw/rtl/erpm_in_if.sv
hw/rtl/erpm_out_if.sv
hw/rtl/erpm_div.sv
hw/rtl/encoder_rpm_iir_estimator_top.sv
test/tb.sv
